// File: hdl/cdpl_pkg.sv
// ----------------------------------------------------------------------------
// cdpl_pkg: shared types and constants for the CD audio play-state core
// Item and result layouts, drive status and result codes, the decoded
// operation carried between the front and back parts, and address decoding.
// ----------------------------------------------------------------------------
package cdpl_pkg;

  localparam int FAD_W = 24;

  localparam logic [FAD_W-1:0] STANDBY_FAD     = FAD_W'(150);
  localparam logic [FAD_W-1:0] SESSION_END_RST = FAD_W'(549300);
  localparam logic [3:0]       REPEAT_FOREVER  = 4'd15;

  localparam int FRAMES_PER_SEC = 75;
  localparam int FRAMES_PER_MIN = 60 * FRAMES_PER_SEC;

  // Input modes.
  localparam logic [1:0] MODE_PLAY   = 2'd0;
  localparam logic [1:0] MODE_SEEK   = 2'd1;
  localparam logic [1:0] MODE_SECTOR = 2'd2;

  // Command parameter types.
  localparam logic [2:0] PT_LINEAR  = 3'd1;
  localparam logic [2:0] PT_MSF     = 3'd2;
  localparam logic [2:0] PT_STANDBY = 3'd3;
  localparam logic [2:0] PT_PAUSE   = 3'd4;
  localparam logic [2:0] PT_RESUME  = 3'd7;

  // Drive status.
  localparam logic [1:0] ST_STANDBY = 2'd0;
  localparam logic [1:0] ST_PLAYING = 2'd1;
  localparam logic [1:0] ST_PAUSED  = 2'd2;
  localparam logic [1:0] ST_ENDED   = 2'd3;

  // Result codes.
  localparam logic [1:0] RC_OK         = 2'd0;
  localparam logic [1:0] RC_BAD_TYPE   = 2'd1;
  localparam logic [1:0] RC_EMPTY      = 2'd2;
  localparam logic [1:0] RC_OUT_OF_RNG = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [2:0]       param_type;
    logic [FAD_W-1:0] first_address;
    logic [FAD_W-1:0] second_address;
    logic [3:0]       repeat_count;
    logic             read_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       drive_status;
    logic [3:0]       repeats_left;
    logic [FAD_W-1:0] position_fad;
    logic [FAD_W-1:0] range_start_fad;
    logic [FAD_W-1:0] range_end_fad;
    logic [FAD_W-1:0] sector_fad;
    logic [1:0]       result_code;
    logic             play_started;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PLAY_RANGE,
    OP_PLAY_EMPTY,
    OP_RESUME,
    OP_BAD_TYPE,
    OP_SEEK_POS,
    OP_SEEK_STANDBY,
    OP_SEEK_PAUSE,
    OP_SECTOR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [FAD_W-1:0] start_fad;
    logic [FAD_W-1:0] end_fad;
    logic [3:0]       reps;
    logic             read_ok;
  } cmd_t;

  // Three address bytes, first most significant, as MSF or as a linear address.
  function automatic logic [FAD_W-1:0] decode_address(input logic [FAD_W-1:0] bytes,
                                                      input logic             msf);
    logic [FAD_W-1:0] b0;
    logic [FAD_W-1:0] b1;
    logic [FAD_W-1:0] b2;
    b0 = {{(FAD_W-8){1'b0}}, bytes[23:16]};
    b1 = {{(FAD_W-8){1'b0}}, bytes[15:8]};
    b2 = {{(FAD_W-8){1'b0}}, bytes[7:0]};
    if (msf) begin
      return b0 * FAD_W'(FRAMES_PER_MIN) + b1 * FAD_W'(FRAMES_PER_SEC) + b2;
    end
    return bytes;
  endfunction

endpackage

// File: hdl/cdpl_front.sv
// ----------------------------------------------------------------------------
// cdpl_front: command classifier
// Decodes the addresses of an incoming item, substitutes the session end
// for a zero end address and sorts the item into one back-end operation.
// ----------------------------------------------------------------------------
module cdpl_front (
  input  cdpl_pkg::in_item_t         item_i,
  input  logic [cdpl_pkg::FAD_W-1:0] session_end_i,
  output cdpl_pkg::cmd_t             cmd_o
);
  import cdpl_pkg::*;

  logic             msf;
  logic [FAD_W-1:0] start_fad;
  logic [FAD_W-1:0] end_raw;
  logic [FAD_W-1:0] end_fad;
  logic             linear_or_msf;

  assign msf           = (item_i.param_type == PT_MSF);
  assign linear_or_msf = (item_i.param_type == PT_LINEAR) || msf;
  assign start_fad     = decode_address(item_i.first_address, msf);
  assign end_raw       = decode_address(item_i.second_address, msf);
  assign end_fad       = (end_raw == '0) ? session_end_i : end_raw;

  always_comb begin
    cmd_o.op        = OP_NOP;
    cmd_o.start_fad = start_fad;
    cmd_o.end_fad   = end_fad;
    cmd_o.reps      = item_i.repeat_count;
    cmd_o.read_ok   = item_i.read_ok;
    unique case (item_i.mode)
      MODE_PLAY: begin
        if (linear_or_msf) begin
          cmd_o.op = (start_fad < end_fad) ? OP_PLAY_RANGE : OP_PLAY_EMPTY;
        end else if (item_i.param_type == PT_RESUME) begin
          cmd_o.op = OP_RESUME;
        end else begin
          cmd_o.op = OP_BAD_TYPE;
        end
      end
      MODE_SEEK: begin
        if (linear_or_msf) begin
          cmd_o.op = OP_SEEK_POS;
        end else if (item_i.param_type == PT_STANDBY) begin
          cmd_o.op = OP_SEEK_STANDBY;
        end else if (item_i.param_type == PT_PAUSE) begin
          cmd_o.op = OP_SEEK_PAUSE;
        end else begin
          cmd_o.op = OP_BAD_TYPE;
        end
      end
      MODE_SECTOR: cmd_o.op = OP_SECTOR;
      default:     cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// File: hdl/cdpl_queue.sv
// ----------------------------------------------------------------------------
// cdpl_queue: two-entry command queue
// Decouples the classifier from the state machine so each side can stall
// on its own.
// ----------------------------------------------------------------------------
module cdpl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cdpl_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output cdpl_pkg::cmd_t head_o
);
  import cdpl_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q;
  logic       wr_ptr_d;
  logic       rd_ptr_q;
  logic       rd_ptr_d;
  logic [1:0] count_q;
  logic [1:0] count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/cdpl_back.sv
// ----------------------------------------------------------------------------
// cdpl_back: play-state executor
// Applies one queued operation per cycle to the drive state while the output
// is not stalled, and registers the result for the output channel.
// ----------------------------------------------------------------------------
module cdpl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cdpl_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cdpl_pkg::out_item_t out_data_o
);
  import cdpl_pkg::*;

  logic [1:0]       status_q,   status_d;
  logic [3:0]       repeats_q,  repeats_d;
  logic [FAD_W-1:0] position_q, position_d;
  logic [FAD_W-1:0] start_q,    start_d;
  logic [FAD_W-1:0] end_q,      end_d;
  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        out_d;

  logic [FAD_W-1:0] pos_inc;
  logic             in_range;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pos_inc  = position_q + FAD_W'(1);
  assign in_range = (start_q < end_q) && (position_q >= start_q) && (position_q < end_q);

  always_comb begin
    logic [1:0] code;
    logic       started;
    logic [FAD_W-1:0] sector;
    status_d   = status_q;
    repeats_d  = repeats_q;
    position_d = position_q;
    start_d    = start_q;
    end_d      = end_q;
    code       = RC_OK;
    started    = 1'b0;
    sector     = '0;
    unique case (cmd_i.op)
      OP_PLAY_RANGE: begin
        position_d = cmd_i.start_fad;
        start_d    = cmd_i.start_fad;
        end_d      = cmd_i.end_fad;
        repeats_d  = cmd_i.reps;
        status_d   = ST_PLAYING;
        started    = 1'b1;
      end
      OP_PLAY_EMPTY: code = RC_EMPTY;
      OP_BAD_TYPE:   code = RC_BAD_TYPE;
      OP_RESUME: begin
        if (status_q == ST_PAUSED) begin
          status_d = (position_q > end_q) ? ST_ENDED : ST_PLAYING;
        end
      end
      OP_SEEK_POS: begin
        if (status_q == ST_PLAYING) begin
          status_d = ST_PAUSED;
        end
        position_d = cmd_i.start_fad;
        start_d    = cmd_i.start_fad;
      end
      OP_SEEK_PAUSE: begin
        if (status_q == ST_PLAYING) begin
          status_d = ST_PAUSED;
        end
      end
      OP_SEEK_STANDBY: begin
        position_d = STANDBY_FAD;
        start_d    = STANDBY_FAD;
        status_d   = ST_STANDBY;
      end
      OP_SECTOR: begin
        sector = position_q;
        if (status_q == ST_PLAYING) begin
          if (!cmd_i.read_ok) begin
            position_d = position_q - FAD_W'(1);
            status_d   = ST_ENDED;
          end else if (!in_range) begin
            code     = RC_OUT_OF_RNG;
            status_d = ST_ENDED;
          end else if (pos_inc < end_q) begin
            position_d = pos_inc;
          end else if (repeats_q == 4'd0) begin
            position_d = pos_inc;
            status_d   = ST_ENDED;
          end else begin
            // Wrap back to the range start for another pass.
            if (repeats_q != REPEAT_FOREVER) begin
              repeats_d = repeats_q - 4'd1;
            end
            position_d = start_q;
          end
        end
      end
      default: ;
    endcase
    out_d.drive_status    = status_d;
    out_d.repeats_left    = repeats_d;
    out_d.position_fad    = position_d;
    out_d.range_start_fad = start_d;
    out_d.range_end_fad   = end_d;
    out_d.sector_fad      = sector;
    out_d.result_code     = code;
    out_d.play_started    = started;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= ST_STANDBY;
      repeats_q   <= 4'd0;
      position_q  <= STANDBY_FAD;
      start_q     <= STANDBY_FAD;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        status_q   <= status_d;
        repeats_q  <= repeats_d;
        position_q <= position_d;
        start_q    <= start_d;
        end_q      <= end_d;
      end
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

// File: hdl/cdda_drive_play_state_core.sv
// ----------------------------------------------------------------------------
// cdda_drive_play_state_core: CD audio play-state core
// An accepted item is written into the command queue; its result is registered in the executor.
// Throughput: one item per cycle while the output is not stalled.
// The two-entry command queue absorbs output stalls before input stalls.
// Reset (rst_ni low, asynchronous): standby, position and start 150, end 0,
// no repeats, queue empty, session end back to 549300.
// ----------------------------------------------------------------------------
module cdda_drive_play_state_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cdpl_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cdpl_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cdpl_pkg::FAD_W-1:0]   cfg_data_i
);
  import cdpl_pkg::*;

  logic [FAD_W-1:0] session_end_q;
  cmd_t             front_cmd;
  cmd_t             head_cmd;
  logic             queue_full;
  logic             queue_valid;
  logic             queue_pop;
  logic             in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full;
  assign in_accept   = in_valid_i && !queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_end_q <= SESSION_END_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      session_end_q <= cfg_data_i;
    end
  end

  cdpl_front u_front (
    .item_i        (in_data_i),
    .session_end_i (session_end_q),
    .cmd_o         (front_cmd)
  );

  cdpl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_cmd),
    .pop_i       (queue_pop),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .head_o      (head_cmd)
  );

  cdpl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the CD audio play-state core
// A directed table covers reset state, the field extremes, every command
// type and the corner cases of play, seek and sector reads. Random phases
// follow: play ranges with runs of sector reads, loose commands and noise.
// Each random phase writes its own session end setting; idle and stall patterns vary.
// Every result transaction is checked field by field against a predictor or a fixed row.
// ----------------------------------------------------------------------------
module tb;
  import cdpl_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [2:0] PT_NONE      = 3'd0;
  localparam int         RAND_PHASES  = 6;
  localparam int         PHASE_ITEMS  = 188;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 8;

  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [FAD_W-1:0] cfg_data_i = '0;

  // Predicted drive state.
  logic [1:0]       drv_status;
  logic [3:0]       drv_reps;
  logic [FAD_W-1:0] drv_pos;
  logic [FAD_W-1:0] drv_range_start;
  logic [FAD_W-1:0] drv_range_end;
  logic [FAD_W-1:0] session_end;

  out_item_t   pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned err_cnt       = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_on       = 1'b0;
  event        hold_start;

  cdda_drive_play_state_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Three address bytes to a frame address, either MSF or linear.
  function automatic logic [FAD_W-1:0] bytes_to_fad(input logic [FAD_W-1:0] bytes,
                                                    input logic             msf);
    int unsigned total;
    if (!msf) begin
      return bytes;
    end
    total = bytes[23:16] * FRAMES_PER_MIN + bytes[15:8] * FRAMES_PER_SEC + bytes[7:0];
    return FAD_W'(total);
  endfunction

  task automatic advance_play_state(input in_item_t it, output out_item_t res);
    logic [FAD_W-1:0] s_fad;
    logic [FAD_W-1:0] e_fad;
    logic [FAD_W-1:0] sector;
    logic [1:0]       code;
    logic             started;
    code    = RC_OK;
    started = 1'b0;
    sector  = '0;
    case (it.mode)
      MODE_PLAY: begin
        if (it.param_type == PT_LINEAR || it.param_type == PT_MSF) begin
          s_fad = bytes_to_fad(it.first_address, it.param_type == PT_MSF);
          e_fad = bytes_to_fad(it.second_address, it.param_type == PT_MSF);
          if (e_fad == '0) e_fad = session_end;
          if (s_fad < e_fad) begin
            drv_pos         = s_fad;
            drv_range_start = s_fad;
            drv_range_end   = e_fad;
            drv_reps        = it.repeat_count;
            drv_status      = ST_PLAYING;
            started         = 1'b1;
          end else begin
            code = RC_EMPTY;
          end
        end else if (it.param_type == PT_RESUME) begin
          if (drv_status == ST_PAUSED) begin
            drv_status = (drv_pos > drv_range_end) ? ST_ENDED : ST_PLAYING;
          end
        end else begin
          code = RC_BAD_TYPE;
        end
      end
      MODE_SEEK: begin
        if (it.param_type >= PT_LINEAR && it.param_type <= PT_PAUSE) begin
          if (drv_status == ST_PLAYING) drv_status = ST_PAUSED;
          if (it.param_type == PT_LINEAR || it.param_type == PT_MSF) begin
            s_fad           = bytes_to_fad(it.first_address, it.param_type == PT_MSF);
            drv_pos         = s_fad;
            drv_range_start = s_fad;
          end else if (it.param_type == PT_STANDBY) begin
            drv_pos         = STANDBY_FAD;
            drv_range_start = STANDBY_FAD;
            drv_status      = ST_STANDBY;
          end
        end else begin
          code = RC_BAD_TYPE;
        end
      end
      MODE_SECTOR: begin
        sector = drv_pos;
        if (drv_status == ST_PLAYING) begin
          if (!it.read_ok) begin
            drv_pos    = drv_pos - 1'b1;
            drv_status = ST_ENDED;
          end else if (!(drv_range_start < drv_range_end && sector >= drv_range_start &&
                         sector < drv_range_end)) begin
            code       = RC_OUT_OF_RNG;
            drv_status = ST_ENDED;
          end else begin
            drv_pos = drv_pos + 1'b1;
            if (drv_pos >= drv_range_end) begin
              if (drv_reps == 4'd0) begin
                drv_status = ST_ENDED;
              end else begin
                if (drv_reps != REPEAT_FOREVER) drv_reps = drv_reps - 1'b1;
                drv_pos = drv_range_start;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    res = '{drv_status, drv_reps, drv_pos, drv_range_start, drv_range_end,
            sector, code, started};
  endtask

  function automatic in_item_t make_item(input logic [1:0] mode, input logic [2:0] ptype,
                                         input logic [FAD_W-1:0] first,
                                         input logic [FAD_W-1:0] second,
                                         input logic [3:0] reps, input logic ok);
    return '{mode, ptype, first, second, reps, ok};
  endfunction

  function automatic void add_row(input in_item_t item, input logic fixed = 1'b0,
                                  input out_item_t want = '0);
    stim_row_t row;
    row = '{item, fixed, want};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic send_item(input in_item_t item, input logic fixed = 1'b0,
                           input out_item_t want = '0);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    advance_play_state(item, predicted);
    pending_results.insert(pending_results.size(), fixed ? want : predicted);
  endtask

  task automatic settle_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_session_end(input logic [FAD_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    session_end = value;
  endtask

  // Random traffic: mostly play ranges followed by runs of sector reads,
  // plus loose commands and fully random noise.
  task automatic run_random(input int n);
    int          sent;
    int          ticks;
    int unsigned pick;
    logic [2:0]  ptype;
    logic [FAD_W-1:0] first;
    logic [FAD_W-1:0] second;
    in_item_t    item;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        ptype = $urandom_range(1) ? PT_LINEAR : PT_MSF;
        if (ptype == PT_LINEAR) begin
          first  = $urandom_range(1) ? FAD_W'($urandom_range(300)) : FAD_W'($urandom);
          second = first + FAD_W'($urandom_range(1, 24));
        end else begin
          first  = {8'($urandom_range(79)), 8'($urandom_range(59)), 8'($urandom_range(74))};
          second = first + FAD_W'($urandom_range(1, 12));
        end
        if ($urandom_range(9) == 0) second = '0;
        send_item(make_item(MODE_PLAY, ptype, first, second, 4'($urandom), 1'($urandom)));
        sent++;
        ticks = $urandom_range(1, 40);
        for (int t = 0; t < ticks && sent < n; t++) begin
          if ($urandom_range(11) == 0) begin
            send_item(make_item(MODE_SEEK, PT_PAUSE, FAD_W'($urandom), FAD_W'($urandom),
                                4'($urandom), 1'($urandom)));
            send_item(make_item(MODE_PLAY, PT_RESUME, FAD_W'($urandom), FAD_W'($urandom),
                                4'($urandom), 1'($urandom)));
            sent += 2;
          end else begin
            send_item(make_item(MODE_SECTOR, 3'($urandom), FAD_W'($urandom),
                                FAD_W'($urandom), 4'($urandom),
                                $urandom_range(19) != 0));
            sent++;
          end
        end
      end else if (pick < 80) begin
        first  = $urandom_range(1) ? FAD_W'($urandom_range(400)) : FAD_W'($urandom);
        second = $urandom_range(3) == 0 ? '0 : FAD_W'($urandom);
        send_item(make_item(2'($urandom_range(1)), 3'($urandom), first, second,
                            4'($urandom), 1'($urandom)));
        sent++;
      end else begin
        item = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
        send_item(item);
        if (item.mode != MODE_UNUSED) sent++;
      end
    end
  endtask

  // Output side: random stall, forced high during a long hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
  end

  initial begin
    forever begin
      @(hold_start);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("drive_status", want.drive_status, out_data_o.drive_status);
        check_field("repeats_left", want.repeats_left, out_data_o.repeats_left);
        check_field("position_fad", want.position_fad, out_data_o.position_fad);
        check_field("range_start_fad", want.range_start_fad, out_data_o.range_start_fad);
        check_field("range_end_fad", want.range_end_fad, out_data_o.range_end_fad);
        check_field("sector_fad", want.sector_fad, out_data_o.sector_fad);
        check_field("result_code", want.result_code, out_data_o.result_code);
        check_field("play_started", want.play_started, out_data_o.play_started);
      end
    end
  end

  initial begin
    drv_status      = ST_STANDBY;
    drv_reps        = 4'd0;
    drv_pos         = STANDBY_FAD;
    drv_range_start = STANDBY_FAD;
    drv_range_end   = '0;
    session_end     = SESSION_END_RST;

    // Reset state seen by a sector read in standby, then a bad play type.
    add_row(make_item(MODE_SECTOR, PT_NONE, '0, '0, 4'd0, 1'b1), 1'b1,
            '{ST_STANDBY, 4'd0, STANDBY_FAD, STANDBY_FAD, FAD_W'(0), STANDBY_FAD,
              RC_OK, 1'b0});
    add_row(make_item(MODE_PLAY, PT_NONE, '0, '0, 4'd0, 1'b0), 1'b1,
            '{ST_STANDBY, 4'd0, STANDBY_FAD, STANDBY_FAD, FAD_W'(0), FAD_W'(0),
              RC_BAD_TYPE, 1'b0});
    // Zero end takes the session end; an all-ones range is empty.
    add_row(make_item(MODE_PLAY, PT_LINEAR, '0, '0, 4'd3, 1'b0), 1'b1,
            '{ST_PLAYING, 4'd3, FAD_W'(0), FAD_W'(0), SESSION_END_RST, FAD_W'(0),
              RC_OK, 1'b1});
    add_row(make_item(MODE_PLAY, PT_LINEAR, '1, '1, 4'hf, 1'b1), 1'b1,
            '{ST_PLAYING, 4'd3, FAD_W'(0), FAD_W'(0), SESSION_END_RST, FAD_W'(0),
              RC_EMPTY, 1'b0});
    // Failed read at frame zero wraps the position.
    add_row(make_item(MODE_PLAY, PT_LINEAR, FAD_W'(0), FAD_W'(5), 4'd0, 1'b0));
    add_row(make_item(MODE_SECTOR, PT_NONE, '0, '0, 4'd0, 1'b0));
    // MSF range of three frames with one repeat, read through to the end.
    add_row(make_item(MODE_PLAY, PT_MSF, FAD_W'(24'h000200), FAD_W'(24'h000203), 4'd1,
                      1'b0));
    repeat (6) add_row(make_item(MODE_SECTOR, PT_NONE, '1, '1, 4'hf, 1'b1));
    add_row(make_item(MODE_PLAY, PT_RESUME, '0, '0, 4'd0, 1'b0));
    // Pause and resume, then a seek that moves past the end before resuming.
    add_row(make_item(MODE_PLAY, PT_LINEAR, FAD_W'(16), FAD_W'(32), REPEAT_FOREVER, 1'b0));
    add_row(make_item(MODE_SEEK, PT_PAUSE, '0, '0, 4'd0, 1'b0));
    add_row(make_item(MODE_PLAY, PT_RESUME, '0, '0, 4'd0, 1'b0));
    add_row(make_item(MODE_SEEK, PT_LINEAR, FAD_W'(256), '0, 4'd0, 1'b0));
    add_row(make_item(MODE_PLAY, PT_RESUME, '0, '0, 4'd0, 1'b0));
    add_row(make_item(MODE_SEEK, PT_NONE, '0, '0, 4'd0, 1'b0));
    add_row(make_item(MODE_SEEK, PT_RESUME, '0, '0, 4'd0, 1'b0));
    add_row(make_item(MODE_UNUSED, PT_LINEAR, '1, '1, 4'hf, 1'b1));
    // Seek to the range end and resume: the next good read is out of range.
    add_row(make_item(MODE_PLAY, PT_LINEAR, FAD_W'(16), FAD_W'(32), 4'd2, 1'b0));
    add_row(make_item(MODE_SEEK, PT_LINEAR, FAD_W'(32), '0, 4'd0, 1'b0));
    add_row(make_item(MODE_PLAY, PT_RESUME, '0, '0, 4'd0, 1'b0));
    add_row(make_item(MODE_SECTOR, PT_NONE, '0, '0, 4'd0, 1'b1));
    add_row(make_item(MODE_SEEK, PT_STANDBY, '0, '0, 4'd0, 1'b0));
    add_row(make_item(MODE_PLAY, PT_MSF, '1, '0, 4'd0, 1'b0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_session_end(SESSION_END_RST);
    send_idle_pct = 35;
    stall_pct     = 35;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_results();
      case (ph)
        0: write_session_end('0);
        1: write_session_end('1);
        2: write_session_end(FAD_W'(200));
        3: write_session_end(FAD_W'($urandom));
        4: write_session_end(SESSION_END_RST);
        default: write_session_end(FAD_W'(1));
      endcase
      case (ph)
        0, 4: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 70;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 70;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct     = 35;
        end
      endcase
      // The long hold-off lets the core fill up while items keep coming.
      if (ph == 4) -> hold_start;
      run_random(PHASE_ITEMS);
    end

    settle_results();
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
